@@ hw/rtl/multichannel_discharge_scan_sequencer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the discharge scan sequencer
// Concurrent checks written once and used by the RTL files that assert.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_DISCHARGE_SCAN_SEQUENCER_UNIT_ASSERT_SVH
`define MULTICHANNEL_DISCHARGE_SCAN_SEQUENCER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDSS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mdss_pkg.sv @@
// ----------------------------------------------------------------------------
// mdss_pkg
// Shared types and codes of the discharge scan sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mdss_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_START    = 2'd1,
    REQ_CLASSIFY = 2'd2,
    REQ_NONE     = 2'd3
  } req_code_t;

  typedef enum logic [2:0] {
    PH_STOP   = 3'd0,
    PH_SELECT = 3'd1,
    PH_SETTLE = 3'd2,
    PH_CMD    = 3'd3,
    PH_WAIT   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_STOPPED    = 3'd0,
    ACT_SELECT     = 3'd1,
    ACT_SETTLING   = 3'd2,
    ACT_READ_CMD   = 3'd3,
    ACT_WAIT_READY = 3'd4,
    ACT_SAMPLED    = 3'd5,
    ACT_LINE_DONE  = 3'd6,
    ACT_CLASSIFIED = 3'd7
  } action_t;

  localparam logic [1:0] WARN_NORMAL    = 2'd0;
  localparam logic [1:0] WARN_REVERSED  = 2'd1;
  localparam logic [1:0] WARN_IMPENDING = 2'd2;

  // register word indexes on the APB port
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_CUTOFF  = 3'd0;
  localparam logic [2:0] REG_REVERSE = 3'd1;
  localparam logic [2:0] REG_LIMIT   = 3'd2;
  localparam logic [2:0] REG_SETTLE  = 3'd3;
  localparam logic [2:0] REG_COUNT   = 3'd4;

  localparam logic [7:0] SETTLE_RESET = 8'd13;
  localparam logic [7:0] COUNT_RESET  = 8'd100;

  typedef struct packed {
    logic [15:0] cutoff_level;
    logic [15:0] reverse_level;
    logic [15:0] limit_level;
    logic [7:0]  settle_ticks;
    logic [7:0]  channel_count;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/mdss_ifs.sv @@
// ----------------------------------------------------------------------------
// mdss request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mdss_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        drdy_n;
  logic [15:0] sample;
  logic [6:0]  class_channel;
  logic        channel_enabled;
  logic        reverse_detected;

  modport source (
    output valid, req_type, drdy_n, sample, class_channel, channel_enabled,
           reverse_detected,
    input  ready
  );
  modport sink (
    input  valid, req_type, drdy_n, sample, class_channel, channel_enabled,
           reverse_detected,
    output ready
  );
endinterface

interface mdss_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  channel_number;
  logic [15:0] sample_out;
  logic        relay_close;
  logic        relay_open;
  logic [1:0]  warn_status;
  logic        channel_working;

  modport source (
    output valid, action, channel_number, sample_out, relay_close, relay_open,
           warn_status, channel_working,
    input  ready
  );
  modport sink (
    input  valid, action, channel_number, sample_out, relay_close, relay_open,
           warn_status, channel_working,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/multichannel_discharge_scan_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_discharge_scan_sequencer_unit
// Tick-driven channel scanner and pre-test classifier of a discharge tester.
// ----------------------------------------------------------------------------
//  channel | kind          | carries
//  req     | valid/ready   | tick, start or classify request with ADC sample
//  rsp     | valid/ready   | action, channel, sample, relay and warn flags
//  apb     | APB write/rd  | cutoff, reverse, limit, settle ticks, count
//
//  One item per cycle while results are taken. Each item is held in the input
//  register, stepped, and its result is loaded into the result register.
//  A stalled result holds the step stage; the input register then fills and
//  ready drops until the result is taken.
//  Reset stops the scan; the working flags are then cleared one per cycle,
//  and ready stays low until all MAX_CHANNELS entries are cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multichannel_discharge_scan_sequencer_unit
  import mdss_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 128
) (
  input  logic              clk,
  input  logic              rst,
  mdss_req_if.sink          req,
  mdss_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "multichannel_discharge_scan_sequencer_unit_assert.svh"

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [8:0]  MAX9  = 9'(MAX_CHANNELS);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_CHANNELS - 1);

  typedef struct packed {
    logic [1:0]  req_type;
    logic        drdy_n;
    logic [15:0] sample;
    logic [6:0]  class_channel;
    logic        channel_enabled;
    logic        reverse_detected;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  channel_number;
    logic [15:0] sample_out;
    logic        relay_close;
    logic        relay_open;
    logic [1:0]  warn_status;
    logic        channel_working;
  } result_t;

  cfg_t cfg;

  mdss_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic  s1_valid;
  item_t s1;
  logic  s1_adv;
  logic  s1_fire;

  // scan state
  phase_t              phase, phase_next;
  logic [7:0]          settle_count, settle_next;
  logic [7:0]          cur_ch, cur_ch_next;

  // working flag store
  logic             flag_mem [MAX_CHANNELS];
  logic             flag_q;
  logic             clr_busy;
  logic [IDX_W-1:0] clr_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic             mem_wd;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_fwd;

  // result register
  logic    out_valid;
  result_t out_q, res;

  // step decode
  logic [8:0]       count9;
  logic [8:0]       ch9;
  logic [8:0]       cls9;
  logic [IDX_W-1:0] ch_idx;
  logic [IDX_W-1:0] cls_idx;
  logic             line_end;
  logic             cur_flag;
  logic             cls_in_range;
  logic             cls_on;
  logic [1:0]       cls_warn;
  logic             clear_flag;
  logic [7:0]       settle_inc;
  logic             is_tick;

  assign s1_adv    = !out_valid || rsp.ready;
  assign s1_fire   = s1_valid && s1_adv;
  assign req.ready = !clr_busy && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.req_type         <= req.req_type;
      s1.drdy_n           <= req.drdy_n;
      s1.sample           <= req.sample;
      s1.class_channel    <= req.class_channel;
      s1.channel_enabled  <= req.channel_enabled;
      s1.reverse_detected <= req.reverse_detected;
    end
  end

  // clamp the count to the flag store depth
  assign count9   = ({1'b0, cfg.channel_count} > MAX9) ? MAX9 : {1'b0, cfg.channel_count};
  assign ch9      = {1'b0, cur_ch};
  assign cls9     = {2'b00, s1.class_channel};
  assign ch_idx   = ch9[IDX_W-1:0];
  assign cls_idx  = cls9[IDX_W-1:0];
  assign line_end = ch9 >= count9;
  assign cur_flag = flag_q;
  assign cls_in_range = cls9 < MAX9;
  assign settle_inc   = settle_count + 8'd1;
  assign is_tick      = (s1.req_type == REQ_TICK) && (phase != PH_STOP);

  assign clear_flag = is_tick && !line_end && (phase == PH_WAIT) && !s1.drdy_n
                      && (s1.sample < cfg.cutoff_level) && cur_flag;

  always_comb begin
    cls_on   = 1'b0;
    cls_warn = WARN_NORMAL;
    priority if (s1.sample > cfg.cutoff_level && s1.channel_enabled) begin
      cls_on = 1'b1;
    end else if (s1.sample < cfg.reverse_level && s1.reverse_detected) begin
      cls_warn = WARN_REVERSED;
    end else if (s1.sample < cfg.limit_level && !s1.reverse_detected) begin
      cls_warn = WARN_IMPENDING;
    end
  end

  // next scan state
  always_comb begin
    phase_next  = phase;
    settle_next = settle_count;
    cur_ch_next = cur_ch;
    if (s1.req_type == REQ_START) begin
      phase_next  = PH_SELECT;
      settle_next = 8'd0;
      cur_ch_next = 8'd0;
    end else if (is_tick) begin
      if (line_end) begin
        phase_next = PH_STOP;
      end else begin
        unique case (phase)
          PH_SELECT: phase_next = PH_SETTLE;
          PH_SETTLE: begin
            if (settle_inc >= cfg.settle_ticks) begin
              settle_next = 8'd0;
              phase_next  = PH_CMD;
            end else begin
              settle_next = settle_inc;
            end
          end
          PH_CMD: phase_next = PH_WAIT;
          PH_WAIT: begin
            if (!s1.drdy_n) begin
              cur_ch_next = cur_ch + 8'd1;
              phase_next  = PH_SELECT;
            end
          end
          default: phase_next = PH_STOP;
        endcase
      end
    end
  end

  // result of the item
  always_comb begin
    res = '0;
    if (s1.req_type == REQ_CLASSIFY) begin
      res.action          = ACT_CLASSIFIED;
      res.channel_number  = cls9[7:0] + 8'd1;
      res.relay_close     = cls_on;
      res.warn_status     = cls_warn;
      res.channel_working = cls_on && cls_in_range;
    end else if (is_tick) begin
      if (line_end) begin
        res.action         = ACT_LINE_DONE;
        res.channel_number = cur_ch;
      end else begin
        res.channel_number  = cur_ch + 8'd1;
        res.channel_working = cur_flag && !clear_flag;
        unique case (phase)
          PH_SELECT: res.action = ACT_SELECT;
          PH_SETTLE: res.action = ACT_SETTLING;
          PH_CMD:    res.action = ACT_READ_CMD;
          PH_WAIT: begin
            if (s1.drdy_n) begin
              res.action = ACT_WAIT_READY;
            end else begin
              res.action     = ACT_SAMPLED;
              res.sample_out = s1.sample;
              res.relay_open = clear_flag;
            end
          end
          default: begin
            res.channel_number  = 8'd0;
            res.channel_working = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STOP;
      settle_count <= 8'd0;
      cur_ch       <= 8'd0;
    end else if (s1_fire) begin
      phase        <= phase_next;
      settle_count <= settle_next;
      cur_ch       <= cur_ch_next;
    end
  end

  // clear the flag store one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + IDX_W'(1);
      if (clr_idx == CLR_LAST) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // classify and sample clear never share a cycle
  assign mem_we = s1_fire && ((s1.req_type == REQ_CLASSIFY && cls_in_range) || clear_flag);
  assign mem_wa = clear_flag ? ch_idx : cls_idx;
  assign mem_wd = clear_flag ? 1'b0 : cls_on;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      flag_mem[clr_idx] <= 1'b0;
    end else if (mem_we) begin
      flag_mem[mem_wa] <= mem_wd;
    end
  end

  // hold the flag of the channel the scan will report next; a classify of
  // that very channel is passed straight through
  assign rd_idx = cur_ch_next[IDX_W-1:0];
  assign rd_fwd = (s1.req_type == REQ_CLASSIFY) && cls_in_range && (cls9 == ch9);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_q <= 1'b0;
    end else if (s1_fire) begin
      flag_q <= rd_fwd ? cls_on : flag_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.action          = out_q.action;
  assign rsp.channel_number  = out_q.channel_number;
  assign rsp.sample_out      = out_q.sample_out;
  assign rsp.relay_close     = out_q.relay_close;
  assign rsp.relay_open      = out_q.relay_open;
  assign rsp.warn_status     = out_q.warn_status;
  assign rsp.channel_working = out_q.channel_working;

  // a stopped scan stays stopped until a start
  `MDSS_ASSERT_NEXT(a_stop_holds, clk, rst,
    s1_fire && phase == PH_STOP && s1.req_type != REQ_START,
    phase == PH_STOP, "scan left stop without a start")
  // classify leaves the scan untouched
  `MDSS_ASSERT_NEXT(a_classify_no_scan, clk, rst,
    s1_fire && s1.req_type == REQ_CLASSIFY,
    $stable(phase) && $stable(cur_ch) && $stable(settle_count),
    "classify changed scan state")
  // relay open only on a taken sample that ends the channel
  `MDSS_ASSERT_SAME(a_open_sampled, clk, rst,
    out_valid && out_q.relay_open,
    out_q.action == ACT_SAMPLED && !out_q.channel_working,
    "relay open outside a sample")
  // a held item stays in the input register
  `MDSS_ASSERT_NEXT(a_s1_hold, clk, rst,
    s1_valid && !s1_adv,
    s1_valid && $stable(s1), "input register lost a held item")

endmodule

`default_nettype wire

@@ hw/rtl/mdss_apb_regs.sv @@
// ----------------------------------------------------------------------------
// mdss_apb_regs
// APB register file holding the thresholds, settle time and channel count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdss_apb_regs
  import mdss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_level  <= '0;
      cfg.reverse_level <= '0;
      cfg.limit_level   <= '0;
      cfg.settle_ticks  <= SETTLE_RESET;
      cfg.channel_count <= COUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CUTOFF:  cfg.cutoff_level  <= pwdata[15:0];
        REG_REVERSE: cfg.reverse_level <= pwdata[15:0];
        REG_LIMIT:   cfg.limit_level   <= pwdata[15:0];
        REG_SETTLE:  cfg.settle_ticks  <= pwdata[7:0];
        REG_COUNT:   cfg.channel_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CUTOFF:  prdata = {16'd0, cfg.cutoff_level};
      REG_REVERSE: prdata = {16'd0, cfg.reverse_level};
      REG_LIMIT:   prdata = {16'd0, cfg.limit_level};
      REG_SETTLE:  prdata = {24'd0, cfg.settle_ticks};
      REG_COUNT:   prdata = {24'd0, cfg.channel_count};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire
